[rtl/contiguous_page_bitmap_allocator_unit_defines.svh]
// Assertion macros for the page bitmap allocator checker.
// Needs nothing; taken in by the checker file with an include.
`ifndef CONTIGUOUS_PAGE_BITMAP_ALLOCATOR_UNIT_DEFINES_SVH
`define CONTIGUOUS_PAGE_BITMAP_ALLOCATOR_UNIT_DEFINES_SVH

// same-cycle implication
`define CPBA_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CPBA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/cpba_pkg.sv]
// Shared constants, codes and types of the page bitmap allocator.
// No dependencies.
`default_nettype none

package cpba_pkg;

   localparam int NUM_PAGES_DEF  = 1024;
   localparam int MAX_RUN_DEF    = 64;
   localparam int PAGE_SHIFT_DEF = 12;

   localparam int ADDR_W     = 48;
   localparam int RUN_W      = 7;
   localparam int CNT_W      = 11;
   localparam int STAT_W     = 2;
   localparam int WORD_PAGES = 32;
   localparam int POS_W      = $clog2(WORD_PAGES);
   localparam int CSR_IDX_W  = 1;

   localparam logic [CNT_W-1:0] POOL_PAGES_RST = 11'd1024;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_POOL_BASE  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_POOL_PAGES = 1'b1;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK           = 2'd0,
      STAT_NO_SPACE     = 2'd1,
      STAT_BAD          = 2'd2,
      STAT_ALREADY_FREE = 2'd3
   } status_type;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_DECODE = 5'b00010,
      ST_SCAN   = 5'b00100,
      ST_MARK   = 5'b01000,
      ST_FINISH = 5'b10000
   } state_type;

   typedef struct packed {
      logic             clear;
      logic             step;
      logic [RUN_W-1:0] run_length;
   } scan_ctrl_type;

   typedef struct packed {
      logic             hit;
      logic [POS_W-1:0] pos;
   } scan_res_type;

endpackage

`default_nettype wire

[rtl/cpba_if.sv]
// Request and response channel interfaces of the page bitmap allocator.
// Depends on cpba_pkg for field widths.
`default_nettype none

interface cpba_req_if import cpba_pkg::*;;
   logic              valid;
   logic              ready;
   logic              cmd;
   logic [RUN_W-1:0]  run_length;
   logic [ADDR_W-1:0] free_address;

   modport source (output valid, cmd, run_length, free_address, input ready);
   modport sink   (input valid, cmd, run_length, free_address, output ready);
endinterface

interface cpba_rsp_if import cpba_pkg::*;;
   logic              valid;
   logic              ready;
   logic [ADDR_W-1:0] run_address;
   logic [STAT_W-1:0] status;
   logic [CNT_W-1:0]  pages_in_use;

   modport source (output valid, run_address, status, pages_in_use, input ready);
   modport sink   (input valid, run_address, status, pages_in_use, output ready);
endinterface

`default_nettype wire

[rtl/cpba_cell.sv]
// One bitmap cell: holds a word of used bits and passes it down the ring.
// Depends on cpba_pkg.
`default_nettype none

module cpba_cell import cpba_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  shift,
   input  logic [WORD_PAGES-1:0] word_in,
   output logic [WORD_PAGES-1:0] word_out
);

   logic [WORD_PAGES-1:0] word_ff;
   logic [WORD_PAGES-1:0] word_nxt_in;

   always_comb begin
      word_nxt_in = shift ? word_in : word_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff <= '0;
      end else begin
         word_ff <= word_nxt_in;
      end
   end

   assign word_out = word_ff;

endmodule

`default_nettype wire

[rtl/cpba_scan.sv]
// Free-run finder: looks at one bitmap word a cycle while ctrl.step is high, carrying the free run
// length across words. Depends on cpba_pkg.
`default_nettype none

module cpba_scan import cpba_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  scan_ctrl_type         ctrl,
   input  logic [WORD_PAGES-1:0] word,
   output scan_res_type          res
);

   localparam int MW = WORD_PAGES + 1;
   localparam logic [RUN_W-1:0] CARRY_MAX = '1;

   logic [RUN_W-1:0]      carry_ff;
   logic [RUN_W-1:0]      carry_in;
   logic [WORD_PAGES-1:0] hit_vec;
   logic [POS_W-1:0]      pos;
   logic [MW-1:0]         word_x;

   always_comb begin
      int            nn;
      int            low;
      logic [MW-1:0] m;
      nn     = int'(ctrl.run_length);
      low    = 0;
      word_x = MW'(word);
      hit_vec = '0;
      for (int p = 0; p < WORD_PAGES; p++) begin
         m = (MW'(2) << p) - MW'(1);
         if (nn <= p + 1) begin
            low = p + 1 - nn;
            m = m & ~((MW'(1) << low) - MW'(1));
            hit_vec[p] = (word_x & m) == '0;
         end else begin
            hit_vec[p] = ((word_x & m) == '0) && (int'(carry_ff) >= nn - (p + 1));
         end
      end
   end

   always_comb begin
      pos = '0;
      for (int p = WORD_PAGES - 1; p >= 0; p--) begin
         if (hit_vec[p]) begin
            pos = POS_W'(p);
         end
      end
   end

   always_comb begin
      int               top_used;
      logic [RUN_W:0]   csum;
      logic [RUN_W-1:0] nxt;
      top_used = -1;
      for (int i = 0; i < WORD_PAGES; i++) begin
         if (word[i]) begin
            top_used = i;
         end
      end
      csum = {1'b0, carry_ff} + (RUN_W+1)'(WORD_PAGES);
      if (top_used < 0) begin
         nxt = csum[RUN_W] ? CARRY_MAX : csum[RUN_W-1:0];
      end else begin
         nxt = RUN_W'(WORD_PAGES - 1 - top_used);
      end
      if (ctrl.clear) begin
         carry_in = '0;
      end else if (ctrl.step) begin
         carry_in = nxt;
      end else begin
         carry_in = carry_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         carry_ff <= '0;
      end else begin
         carry_ff <= carry_in;
      end
   end

   assign res.hit = ctrl.step && (hit_vec != '0);
   assign res.pos = pos;

endmodule

`default_nettype wire

[rtl/contiguous_page_bitmap_allocator_unit.sv]
// Allocate scans the bitmap and, on success, marks the run; free scans it and clears
// the page; bad requests skip the ring. One transaction in flight at a time; the next
// is accepted while the previous response still waits. Time is set by the ring of
// NW = ceil(NUM_PAGES/32) bitmap cells: a full revolution to search, another to mark.
// Synchronous reset clears the bitmap, count, state, pool base and flags; pool pages
// resets to 1024. Depends on cpba_pkg, cpba_if, cpba_cell and cpba_scan.
`default_nettype none

module contiguous_page_bitmap_allocator_unit import cpba_pkg::*; #(
   parameter int NUM_PAGES  = NUM_PAGES_DEF,
   parameter int MAX_RUN    = MAX_RUN_DEF,
   parameter int PAGE_SHIFT = PAGE_SHIFT_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   cpba_req_if.sink             req_chan,
   cpba_rsp_if.source           rsp_chan,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [ADDR_W-1:0]    csr_wdata
);

   localparam int NW    = (NUM_PAGES + WORD_PAGES - 1) / WORD_PAGES;
   localparam int WI_W  = (NW > 1) ? $clog2(NW) : 1;
   localparam int IDX_W = WI_W + POS_W;
   localparam int UCW   = $clog2(NUM_PAGES + 1);
   localparam int UW    = (UCW > CNT_W) ? UCW : CNT_W;
   localparam int GW    = (IDX_W + 1 > UW) ? IDX_W + 1 : UW;

   state_type state_ff, state_in;

   logic [ADDR_W-1:0] pool_base_ff, pool_base_in;
   logic [CNT_W-1:0]  pool_pages_ff, pool_pages_in;
   logic [UW-1:0]     usable;

   logic              cmd_ff;
   logic [RUN_W-1:0]  n_ff;
   logic [ADDR_W-1:0] faddr_ff;
   logic              bad_ff, bad_in;
   logic [IDX_W-1:0]  fidx_ff, fidx_in;
   logic [WI_W-1:0]   wcnt_ff, wcnt_in;
   logic              hit_ff, hit_in;
   logic [IDX_W-1:0]  end_ff, end_in;
   logic [IDX_W-1:0]  start_ff, start_in;
   logic              freeok_ff, freeok_in;
   logic [UCW-1:0]    used_ff, used_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0] rsp_addr_ff, rsp_addr_in;
   status_type        rsp_stat_ff, rsp_stat_in;
   logic [CNT_W-1:0]  rsp_cnt_ff, rsp_cnt_in;

   logic                  shift;
   logic [WORD_PAGES-1:0] cell_word [NW];
   logic [WORD_PAGES-1:0] head, head_forced, tail_word, mark_mask;
   logic                  last_word, free_here;
   scan_ctrl_type         sctrl;
   scan_res_type          sres;

   // usable pool size
   always_comb begin
      logic [CNT_W-1:0] pp8;
      pp8 = pool_pages_ff & ~CNT_W'(7);
      if (UW'(pp8) > UW'(NUM_PAGES)) begin
         usable = UW'(NUM_PAGES);
      end else begin
         usable = UW'(pp8);
      end
   end

   always_comb begin
      pool_base_in  = pool_base_ff;
      pool_pages_in = pool_pages_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_POOL_BASE:  pool_base_in  = csr_wdata;
            CSR_POOL_PAGES: pool_pages_in = csr_wdata[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   // bitmap ring
   assign shift     = (state_ff == ST_SCAN) || (state_ff == ST_MARK);
   assign head      = cell_word[0];
   assign last_word = (wcnt_ff == WI_W'(NW - 1));
   assign free_here = (cmd_ff == CMD_FREE) && (wcnt_ff == fidx_ff[IDX_W-1:POS_W]);

   always_comb begin
      logic [GW-1:0] g;
      head_forced = head;
      mark_mask   = '0;
      for (int i = 0; i < WORD_PAGES; i++) begin
         g = GW'({wcnt_ff, POS_W'(i)});
         if (g >= GW'(usable)) begin
            head_forced[i] = 1'b1;
         end
         mark_mask[i] = (g >= GW'(start_ff)) && (g <= GW'(end_ff));
      end
   end

   always_comb begin
      tail_word = head;
      if (state_ff == ST_MARK) begin
         tail_word = head | mark_mask;
      end else if (state_ff == ST_SCAN && free_here) begin
         tail_word[fidx_ff[POS_W-1:0]] = 1'b0;
      end
   end

   for (genvar c = 0; c < NW; c++) begin : g_cell
      logic [WORD_PAGES-1:0] nbr;
      if (c == NW - 1) begin : g_tail
         assign nbr = tail_word;
      end else begin : g_mid
         assign nbr = cell_word[c+1];
      end
      cpba_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift    (shift),
         .word_in  (nbr),
         .word_out (cell_word[c])
      );
   end

   assign sctrl.clear      = (state_ff == ST_DECODE);
   assign sctrl.step       = (state_ff == ST_SCAN) && (cmd_ff == CMD_ALLOC) && !hit_ff;
   assign sctrl.run_length = n_ff;

   cpba_scan u_scan (
      .clock (clock),
      .reset (reset),
      .ctrl  (sctrl),
      .word  (head_forced),
      .res   (sres)
   );

   // control
   always_comb begin
      logic [ADDR_W-1:0] off;
      logic              under, mis, over;
      logic [IDX_W-1:0]  e;
      state_in     = state_ff;
      bad_in       = bad_ff;
      fidx_in      = fidx_ff;
      wcnt_in      = wcnt_ff;
      hit_in       = hit_ff;
      end_in       = end_ff;
      start_in     = start_ff;
      freeok_in    = freeok_ff;
      used_in      = used_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_addr_in  = rsp_addr_ff;
      rsp_stat_in  = rsp_stat_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      off   = faddr_ff - pool_base_ff;
      under = faddr_ff < pool_base_ff;
      mis   = off[PAGE_SHIFT-1:0] != '0;
      over  = (off >> PAGE_SHIFT) >= ADDR_W'(usable);
      e     = {wcnt_ff, sres.pos};
      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            hit_in    = 1'b0;
            freeok_in = 1'b0;
            wcnt_in   = '0;
            fidx_in   = off[PAGE_SHIFT +: IDX_W];
            if (cmd_ff == CMD_ALLOC) begin
               bad_in = (n_ff == '0) || (int'(n_ff) > MAX_RUN);
            end else begin
               bad_in = under || mis || over;
            end
            state_in = bad_in ? ST_FINISH : ST_SCAN;
         end
         ST_SCAN: begin
            wcnt_in = last_word ? '0 : wcnt_ff + WI_W'(1);
            if (sres.hit) begin
               hit_in   = 1'b1;
               end_in   = e;
               start_in = e + IDX_W'(1) - IDX_W'(n_ff);
            end
            if (free_here) begin
               freeok_in = head[fidx_ff[POS_W-1:0]];
            end
            if (last_word) begin
               state_in = (cmd_ff == CMD_ALLOC && hit_in) ? ST_MARK : ST_FINISH;
            end
         end
         ST_MARK: begin
            wcnt_in = last_word ? '0 : wcnt_ff + WI_W'(1);
            if (last_word) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_addr_in = '0;
               if (bad_ff) begin
                  rsp_stat_in = STAT_BAD;
               end else if (cmd_ff == CMD_ALLOC) begin
                  if (hit_ff) begin
                     rsp_stat_in = STAT_OK;
                     rsp_addr_in = pool_base_ff + (ADDR_W'(start_ff) << PAGE_SHIFT);
                     used_in     = used_ff + UCW'(n_ff);
                  end else begin
                     rsp_stat_in = STAT_NO_SPACE;
                  end
               end else if (freeok_ff) begin
                  rsp_stat_in = STAT_OK;
                  if (used_ff != '0) begin
                     used_in = used_ff - UCW'(1);
                  end
               end else begin
                  rsp_stat_in = STAT_ALREADY_FREE;
               end
               rsp_cnt_in   = CNT_W'(used_in);
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pool_base_ff  <= '0;
         pool_pages_ff <= POOL_PAGES_RST;
         used_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
         bad_ff        <= 1'b0;
         hit_ff        <= 1'b0;
         freeok_ff     <= 1'b0;
         wcnt_ff       <= '0;
      end else begin
         state_ff      <= state_in;
         pool_base_ff  <= pool_base_in;
         pool_pages_ff <= pool_pages_in;
         used_ff       <= used_in;
         rsp_valid_ff  <= rsp_valid_in;
         bad_ff        <= bad_in;
         hit_ff        <= hit_in;
         freeok_ff     <= freeok_in;
         wcnt_ff       <= wcnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_chan.valid) begin
         cmd_ff   <= req_chan.cmd;
         n_ff     <= req_chan.run_length;
         faddr_ff <= req_chan.free_address;
      end
      fidx_ff     <= fidx_in;
      end_ff      <= end_in;
      start_ff    <= start_in;
      rsp_addr_ff <= rsp_addr_in;
      rsp_stat_ff <= rsp_stat_in;
      rsp_cnt_ff  <= rsp_cnt_in;
   end

   assign req_chan.ready        = (state_ff == ST_IDLE);
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.run_address  = rsp_addr_ff;
   assign rsp_chan.status       = rsp_stat_ff;
   assign rsp_chan.pages_in_use = rsp_cnt_ff;

endmodule

`default_nettype wire

[rtl/cpba_checker.sv]
// Port-level checks for the page bitmap allocator, bound to the top level.
// Depends on cpba_pkg and the allocator defines header.
`default_nettype none
`include "contiguous_page_bitmap_allocator_unit_defines.svh"

module cpba_checker import cpba_pkg::*; (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_ready,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire logic [ADDR_W-1:0] rsp_run_address,
   input wire logic [STAT_W-1:0] rsp_status
);

   `CPBA_ASSERT_NOW(a_fail_addr_zero, clock, reset, rsp_valid && (rsp_status != STAT_OK), rsp_run_address == '0, "failed transaction with non-zero address")
   `CPBA_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready, "second transaction accepted while busy")
   `CPBA_ASSERT_NEXT(a_rsp_held, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "response dropped while stalled")

endmodule

bind contiguous_page_bitmap_allocator_unit cpba_checker u_cpba_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_run_address (rsp_chan.run_address),
   .rsp_status      (rsp_chan.status)
);

`default_nettype wire
